// ----- rtl/shamd_pkg.sv -----
// Shared types, constants and tables for the SHA-256 message digest block.
// Used by the front end, the sequencer, the compression datapath and the top level.
// Depends on nothing else.
package shamd_pkg;

	// Block geometry and padding constants.
	localparam int          QUEUE_DEPTH_DEF = 4;
	localparam logic [3:0]  LAST_SLOT       = 4'd15;
	localparam logic [3:0]  LENGTH_SLOT     = 4'd14;
	localparam logic [2:0]  FULL_WORD_BYTES = 3'd4;
	localparam logic [2:0]  LAST_DIGEST_IDX = 3'd7;
	localparam logic [5:0]  LAST_ROUND      = 6'd63;
	localparam logic [31:0] PAD_WORD        = 32'h8000_0000;
	localparam logic [63:0] WORD_BITS       = 64'd32;

	// Command kinds that the front end hands to the sequencer.
	typedef enum logic [1:0] {
		CMD_DATA,
		CMD_LAST_FULL,
		CMD_LAST_PART
	} cmd_kind_t;

	// One classified input word. For a partial final word the padding byte is
	// already merged into the word.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] word;
		logic [2:0]  nbytes;
	} cmd_t;

	// Control from the sequencer to the compression datapath.
	typedef struct packed {
		logic        wr_en;
		logic [3:0]  wr_idx;
		logic [31:0] wr_data;
		logic        start;
		logic        hash_init;
	} cmp_ctl_t;

	// Rotate right by a constant amount.
	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// Initial hash words.
	function automatic logic [31:0] initial_hash(input logic [2:0] idx);
		logic [31:0] h;
		case (idx)
			3'd0: h = 32'h6a09e667;
			3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372;
			3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f;
			3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			3'd7: h = 32'h5be0cd19;
			default: h = 32'h6a09e667;
		endcase
		return h;
	endfunction

	// Round constants.
	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h428a2f98;
		endcase
		return k;
	endfunction

endpackage

// ----- rtl/sha256_message_digest.sv -----
// SHA-256 message digest, top level. Message words enter a command queue and
// are taken by the sequencer at one word per cycle while it is free; each full 64-byte
// block then holds the sequencer through the 64 rounds and the feed-forward add.
// After the final word the sequencer pads the block, appends the length (in a second
// block when it does not fit) and emits one digest word per cycle while the receiver
// is ready. Reset loads the initial hash and empties the queue.
module sha256_message_digest import shamd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	// Front end: classification and command queue.
	shamd_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_ready      (msg_ready),
		.data_word      (data_word),
		.byte_count     (byte_count),
		.end_of_message (end_of_message),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd)
	);

	// Back end: block fill, padding, compression and digest output.
	shamd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

endmodule

// ----- rtl/shamd_front.sv -----
// Front end of the SHA-256 digest block: classifies incoming message words
// and holds them in a short command queue for the sequencer.
// Depends on shamd_pkg.
module shamd_front import shamd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        end_of_message,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           entry_q [QUEUE_DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  fill_q;
	logic [2:0]     nbytes;
	logic [31:0]    keep_mask;
	logic [31:0]    pad_bits;
	cmd_t           cmd_in;
	logic           push;
	logic           pop;

	// Classify the word: saturate the byte count, mask unused bytes and merge
	// the padding byte into a partial final word.
	always_comb begin
		nbytes = (byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : byte_count;
		case (nbytes)
			3'd0: begin
				keep_mask = 32'h0000_0000;
				pad_bits  = 32'h8000_0000;
			end
			3'd1: begin
				keep_mask = 32'hff00_0000;
				pad_bits  = 32'h0080_0000;
			end
			3'd2: begin
				keep_mask = 32'hffff_0000;
				pad_bits  = 32'h0000_8000;
			end
			3'd3: begin
				keep_mask = 32'hffff_ff00;
				pad_bits  = 32'h0000_0080;
			end
			default: begin
				keep_mask = 32'hffff_ffff;
				pad_bits  = 32'h0000_0000;
			end
		endcase
		cmd_in.nbytes = nbytes;
		if (!end_of_message) begin
			cmd_in.kind = CMD_DATA;
			cmd_in.word = data_word;
		end else if (nbytes == FULL_WORD_BYTES) begin
			cmd_in.kind = CMD_LAST_FULL;
			cmd_in.word = data_word;
		end else begin
			cmd_in.kind = CMD_LAST_PART;
			cmd_in.word = (data_word & keep_mask) | pad_bits;
		end
	end

	// Queue handshakes.
	assign msg_ready = (fill_q != CW'(QUEUE_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = entry_q[rd_ptr_q];
	assign push      = msg_valid && msg_ready;
	assign pop       = cmd_valid && cmd_ready;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/shamd_compress.sv -----
// Compression datapath of the SHA-256 digest block: block buffer that doubles
// as the rolling message schedule, working variables and the hash words.
// Depends on shamd_pkg.
module shamd_compress import shamd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmp_ctl_t    ctl,
	input  logic [2:0]  rd_idx,
	output logic [31:0] rd_word,
	output logic        busy
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_ROUND,
		C_FINAL
	} cmp_state_t;

	cmp_state_t  state_q;
	logic [5:0]  round_q;
	logic [31:0] sched_q [16];
	logic [31:0] work_q  [8];
	logic [31:0] hash_q  [8];
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] sched_next;
	logic [31:0] ch;
	logic [31:0] maj;

	// One round of the compression function and the next schedule word.
	always_comb begin
		ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		t1  = work_q[7] + big_sigma1(work_q[4]) + ch + round_k(round_q) + sched_q[0];
		t2  = big_sigma0(work_q[0]) + maj;
		sched_next = small_sigma1(sched_q[14]) + sched_q[9] + small_sigma0(sched_q[1])
			+ sched_q[0];
	end

	assign busy    = (state_q != C_IDLE);
	assign rd_word = hash_q[rd_idx];

	// Round sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			round_q <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (ctl.start) begin
						state_q <= C_ROUND;
						round_q <= '0;
					end
				end
				C_ROUND: begin
					round_q <= round_q + 1'b1;
					if (round_q == LAST_ROUND) begin
						state_q <= C_FINAL;
					end
				end
				C_FINAL: begin
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	// Block buffer: written word by word while filling, then shifted as the
	// rolling schedule during the rounds.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			sched_q[ctl.wr_idx] <= ctl.wr_data;
		end else if (state_q == C_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[15] <= sched_next;
		end
	end

	// Working variables a through h.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= hash_q[i];
			end
		end else if (state_q == C_ROUND) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	// Hash words: feed forward after the last round, reload for a new message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= initial_hash(3'(i));
			end
		end else if (state_q == C_FINAL) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + work_q[i];
			end
		end else if (ctl.hash_init) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= initial_hash(3'(i));
			end
		end
	end

endmodule

// ----- rtl/shamd_back.sv -----
// Back end of the SHA-256 digest block: fills blocks, appends padding and the
// bit length, starts compressions and emits the digest words.
// Depends on shamd_pkg and shamd_compress.
module shamd_back import shamd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {
		B_TAKE,
		B_PAD,
		B_FILL,
		B_LEN_HI,
		B_LEN_LO,
		B_WAIT,
		B_EMIT
	} back_state_t;

	back_state_t state_q;
	back_state_t resume_q;
	back_state_t nxt;
	logic [3:0]  slot_q;
	logic [63:0] bit_len_q;
	logic [2:0]  emit_idx_q;
	logic        push;
	logic [31:0] push_word;
	logic [63:0] len_add;
	logic        load_out;
	logic        hash_init;
	logic        start;
	logic        busy;
	logic [31:0] rd_word;
	cmp_ctl_t    ctl;

	// Decide what goes into the block buffer this cycle.
	always_comb begin
		push      = 1'b0;
		push_word = '0;
		nxt       = state_q;
		cmd_ready = 1'b0;
		len_add   = '0;
		load_out  = 1'b0;
		hash_init = 1'b0;
		case (state_q)
			B_TAKE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					push      = 1'b1;
					push_word = cmd.word;
					case (cmd.kind)
						CMD_DATA: begin
							nxt     = B_TAKE;
							len_add = WORD_BITS;
						end
						CMD_LAST_FULL: begin
							nxt     = B_PAD;
							len_add = WORD_BITS;
						end
						CMD_LAST_PART: begin
							nxt     = B_FILL;
							len_add = {58'd0, cmd.nbytes, 3'd0};
						end
						default: begin
							nxt = B_TAKE;
						end
					endcase
				end
			end
			B_PAD: begin
				push      = 1'b1;
				push_word = PAD_WORD;
				nxt       = B_FILL;
			end
			B_FILL: begin
				if (slot_q == LENGTH_SLOT) begin
					nxt = B_LEN_HI;
				end else begin
					push = 1'b1;
					nxt  = B_FILL;
				end
			end
			B_LEN_HI: begin
				push      = 1'b1;
				push_word = bit_len_q[63:32];
				nxt       = B_LEN_LO;
			end
			B_LEN_LO: begin
				push      = 1'b1;
				push_word = bit_len_q[31:0];
				nxt       = B_EMIT;
			end
			B_EMIT: begin
				load_out  = !digest_valid || digest_ready;
				hash_init = load_out && (emit_idx_q == LAST_DIGEST_IDX);
			end
			default: begin
				nxt = state_q;
			end
		endcase
		start = push && (slot_q == LAST_SLOT);
	end

	// Control bundle for the compression datapath.
	always_comb begin
		ctl.wr_en     = push;
		ctl.wr_idx    = slot_q;
		ctl.wr_data   = push_word;
		ctl.start     = start;
		ctl.hash_init = hash_init;
	end

	shamd_compress u_compress (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_idx  (emit_idx_q),
		.rd_word (rd_word),
		.busy    (busy)
	);

	// Sequencer state, counters and the digest output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_TAKE;
			resume_q     <= B_TAKE;
			slot_q       <= '0;
			bit_len_q    <= '0;
			emit_idx_q   <= '0;
			digest_valid <= 1'b0;
			digest_word  <= '0;
			word_index   <= '0;
			last_word    <= 1'b0;
		end else begin
			if (push) begin
				slot_q <= slot_q + 1'b1;
			end
			if (cmd_ready && cmd_valid) begin
				bit_len_q <= bit_len_q + len_add;
			end
			if (load_out) begin
				digest_valid <= 1'b1;
				digest_word  <= rd_word;
				word_index   <= emit_idx_q;
				last_word    <= (emit_idx_q == LAST_DIGEST_IDX);
			end else if (digest_ready) begin
				digest_valid <= 1'b0;
			end
			case (state_q)
				B_WAIT: begin
					if (!busy) begin
						state_q <= resume_q;
					end
				end
				B_EMIT: begin
					if (load_out) begin
						emit_idx_q <= emit_idx_q + 1'b1;
						if (emit_idx_q == LAST_DIGEST_IDX) begin
							state_q   <= B_TAKE;
							bit_len_q <= '0;
						end
					end
				end
				default: begin
					if (start) begin
						state_q  <= B_WAIT;
						resume_q <= nxt;
					end else begin
						state_q <= nxt;
					end
				end
			endcase
		end
	end

endmodule

// ----- bench/sha256_message_digest_tb.sv -----
// Self-checking testbench for the SHA-256 message digest block.
// Drives word-level messages over valid/ready and checks each digest word against a
// behavioral SHA-256 model kept here; depends only on the RTL top level.
module sha256_message_digest_tb;

	localparam int ITEM_COUNT   = 280;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES  = 600;
	localparam logic [31:0] PAD_BYTE_WORD = 32'h8000_0000;

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H_INIT [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct {
		logic [31:0] data;
		logic [2:0]  count;
		logic        eom;
	} msg_word_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_ready;
	logic [31:0] data_word = '0;
	logic [2:0]  byte_count = '0;
	logic        end_of_message = 1'b0;
	logic        digest_valid;
	logic        digest_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	msg_word_t     pending_words[$];
	digest_entry_t digest_expect[$];

	// Model state: running hash, partial block and message length.
	logic [31:0] hash_acc [0:7];
	logic [31:0] blk_words [0:15];
	int          blk_fill;
	logic [63:0] bit_total;

	int  total_words = 0;
	int  words_sent = 0;
	int  words_taken = 0;
	logic msg_taken = 1'b0;
	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  hold_left = 0;
	logic hold_done = 1'b0;

	sha256_message_digest i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_ready      (msg_ready),
		.data_word      (data_word),
		.byte_count     (byte_count),
		.end_of_message (end_of_message),
		.digest_valid   (digest_valid),
		.digest_ready   (digest_ready),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	// Clock with a period of four time units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic restart_hash();
		for (int i = 0; i < 8; i++) hash_acc[i] = H_INIT[i];
		blk_fill = 0;
		bit_total = '0;
	endtask

	// One 64-round compression of the buffered block into the running hash.
	task automatic compress_block();
		logic [31:0] sched [0:63];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) sched[i] = blk_words[i];
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
			s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
			sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
		end
		a = hash_acc[0]; b = hash_acc[1]; c = hash_acc[2]; d = hash_acc[3];
		e = hash_acc[4]; f = hash_acc[5]; g = hash_acc[6]; h = hash_acc[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[i] + sched[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_acc[0] += a; hash_acc[1] += b; hash_acc[2] += c; hash_acc[3] += d;
		hash_acc[4] += e; hash_acc[5] += f; hash_acc[6] += g; hash_acc[7] += h;
	endtask

	task automatic absorb_word(input logic [31:0] w);
		blk_words[blk_fill] = w;
		blk_fill++;
		if (blk_fill == 16) begin
			compress_block();
			blk_fill = 0;
		end
	endtask

	// Update the model with one accepted word; a final word queues eight digest words.
	task automatic predict_digest(input logic [31:0] data, input logic [2:0] count,
			input logic eom);
		int nbytes;
		logic [31:0] keep_mask;
		digest_entry_t ent;
		if (!eom) begin
			bit_total += 64'd32;
			absorb_word(data);
			return;
		end
		// A count above four means a full word.
		nbytes = (count > 3'd4) ? 4 : int'(count);
		bit_total += 64'(nbytes * 8);
		if (nbytes == 4) begin
			absorb_word(data);
			absorb_word(PAD_BYTE_WORD);
		end else begin
			keep_mask = (nbytes == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nbytes));
			absorb_word((data & keep_mask) | (32'h80 << (24 - 8 * nbytes)));
		end
		// No room for the length: pad out this block and start another.
		if (blk_fill > 14) begin
			while (blk_fill != 0) absorb_word(32'h0);
		end
		while (blk_fill < 14) absorb_word(32'h0);
		absorb_word(bit_total[63:32]);
		absorb_word(bit_total[31:0]);
		for (int k = 0; k < 8; k++) begin
			ent.word = hash_acc[k];
			ent.index = 3'(k);
			ent.last = (k == 7);
			digest_expect.push_back(ent);
		end
		restart_hash();
	endtask

	task automatic add_word(input logic [31:0] data, input logic [2:0] count, input logic eom);
		msg_word_t w;
		w.data = data;
		w.count = count;
		w.eom = eom;
		pending_words.push_back(w);
	endtask

	// A message of full words with random byte counts, then one final word.
	task automatic add_message(input int nfull, input logic [2:0] final_count);
		for (int i = 0; i < nfull; i++) add_word($urandom, 3'($urandom_range(7)), 1'b0);
		add_word($urandom, final_count, 1'b1);
	endtask

	// Idle percentages per phase: sender light then heavy, then no idling at all.
	function automatic int sender_idle_pct(input int sent);
		if (sent < total_words / 3) return 15;
		if (sent < 2 * total_words / 3) return 88;
		return 0;
	endfunction

	function automatic int receiver_idle_pct(input int sent);
		if (sent < total_words / 3) return 88;
		if (sent < 2 * total_words / 3) return 15;
		return 0;
	endfunction

	// Driver: offer the next word once the current transaction is taken.
	always @(negedge clk) begin
		if (arst_n && (!msg_valid || msg_taken)) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct(words_sent)) begin
				data_word <= pending_words[0].data;
				byte_count <= pending_words[0].count;
				end_of_message <= pending_words[0].eom;
				pending_words.pop_front();
				words_sent <= words_sent + 1;
				msg_valid <= 1'b1;
			end else begin
				msg_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off when the last phase begins.
	always @(negedge clk) begin
		if (!arst_n) begin
			digest_ready <= 1'b0;
		end else if (!hold_done && words_sent >= 2 * total_words / 3) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			digest_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			digest_ready <= 1'b0;
		end else begin
			digest_ready <= ($urandom_range(99) >= receiver_idle_pct(words_sent));
		end
	end

	// Monitor: model each accepted word, check each accepted digest word.
	always @(posedge clk) begin
		digest_entry_t want;
		cycle_count <= cycle_count + 1;
		msg_taken <= arst_n && msg_valid && msg_ready;
		if (arst_n && msg_valid && msg_ready) begin
			predict_digest(data_word, byte_count, end_of_message);
			words_taken <= words_taken + 1;
		end
		if (arst_n && digest_valid && digest_ready) begin
			if (digest_expect.size() == 0) begin
				$error("unexpected digest transaction: digest_word %h word_index %0d",
					digest_word, word_index);
				mismatch_count <= mismatch_count + 1;
			end else begin
				want = digest_expect.pop_front();
				if (digest_word !== want.word) begin
					$error("digest_word mismatch: expected %h, actual %h", want.word, digest_word);
					mismatch_count <= mismatch_count + 1;
				end
				if (word_index !== want.index) begin
					$error("word_index mismatch: expected %0d, actual %0d", want.index, word_index);
					mismatch_count <= mismatch_count + 1;
				end
				if (last_word !== want.last) begin
					$error("last_word mismatch: expected %0b, actual %0b", want.last, last_word);
					mismatch_count <= mismatch_count + 1;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int pick;
		int nfull;
		restart_hash();

		// Directed: empty final word, partial final words, saturated counts.
		add_word(32'hffff_ffff, 3'd0, 1'b1);
		add_word(32'hffff_ffff, 3'd1, 1'b1);
		add_word(32'h1234_5678, 3'd2, 1'b1);
		add_word(32'hffff_ffff, 3'd3, 1'b1);
		add_word(32'h0000_0000, 3'd5, 1'b1);
		add_word(32'hffff_ffff, 3'd7, 1'b1);
		// A non-final word counts as four bytes whatever its byte count says.
		add_word(32'hffff_ffff, 3'd0, 1'b0);
		add_word(32'h0000_0000, 3'd4, 1'b1);
		// Padding that spills into a second block.
		add_message(13, 3'd4);

		// Random messages, mostly short, some spanning several blocks.
		while (pending_words.size() < ITEM_COUNT) begin
			pick = $urandom_range(99);
			if (pick < 70) nfull = $urandom_range(16);
			else if (pick < 90) nfull = $urandom_range(32, 17);
			else nfull = $urandom_range(48, 33);
			// Keep the total close to the intended word count.
			if (nfull > ITEM_COUNT - pending_words.size()) begin
				nfull = ITEM_COUNT - pending_words.size();
			end
			add_message(nfull, 3'($urandom_range(7)));
		end
		total_words = pending_words.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_taken < total_words) @(posedge clk);
		while (digest_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && digest_expect.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
